>>> hw/rtl/icc_pkg.sv
`timescale 1ns / 1ps
package icc_pkg;

  localparam int CHANNELS_DEF    = 4;
  localparam int SUM_MAX_DEF     = 1020;
  localparam int QUEUE_DEPTH_DEF = 2;

  localparam int DYE_W     = 8;
  localparam int NUM_DYES  = 4;
  localparam int NUM_RGB   = 3;
  localparam int SUM_W     = 10;   // holds any SUM_MAX up to 1020
  localparam int MIX_W     = 18;   // 4 * 255 * 255
  localparam int ACC_W     = 16;
  localparam int RCP_W     = 16;
  localparam int GAIN_W    = 16;
  localparam int COL_W     = 24;
  localparam int HUE_W     = 8;
  localparam int CFG_IDX_W = 3;

  localparam logic [7:0]       TRANS_FULL   = 8'd255;
  localparam logic [7:0]       OPAQUE_LIMIT = 8'd3;
  localparam logic [7:0]       ALPHA_CAP    = 8'd255;
  localparam logic [RCP_W-1:0] RCP_CAP      = 16'hFFFF;
  localparam logic [ACC_W-1:0] ACC_CAP      = 16'hFFFF;
  localparam logic [GAIN_W-1:0] GAIN_RST    = 16'd256;
  localparam logic [COL_W-1:0] COLOUR_RST   = 24'hFFFFFF;
  localparam int               DIVIDEND     = 65536;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN    = 3'd0,
    REG_COLOUR0 = 3'd1,
    REG_COLOUR1 = 3'd2,
    REG_COLOUR2 = 3'd3,
    REG_COLOUR3 = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [GAIN_W-1:0]                gain;
    logic [NUM_DYES-1:0][COL_W-1:0]   colour;
  } cfg_t;

  // one classified voxel, as queued between front and back
  typedef struct packed {
    logic                             last;
    logic [SUM_W-1:0]                 sum;
    logic [NUM_RGB-1:0][MIX_W-1:0]    mix;
  } item_t;

  typedef struct packed {
    logic             start;
    logic [SUM_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [RCP_W-1:0] quot;
  } div_rsp_t;

endpackage

>>> hw/rtl/icc_front.sv
`timescale 1ns / 1ps
module icc_front #(
  parameter int CHANNELS = icc_pkg::CHANNELS_DEF,
  parameter int SUM_MAX  = icc_pkg::SUM_MAX_DEF
) (
  input  logic                                             clk,
  input  logic                                             rst_n,
  input  icc_pkg::cfg_t                                    cfg,
  input  logic                                             in_valid,
  output logic                                             in_ready,
  input  logic [icc_pkg::NUM_DYES-1:0][icc_pkg::DYE_W-1:0] in_dyes,
  input  logic                                             in_last,
  output logic                                             push_valid,
  input  logic                                             push_ready,
  output icc_pkg::item_t                                   push_item
);

  logic           st_valid_r;
  icc_pkg::item_t st_item_r;
  icc_pkg::item_t cls;
  logic [icc_pkg::SUM_W-1:0] sum_raw;

  // dye sum and the three colour mixes of one voxel
  always_comb begin
    sum_raw  = '0;
    cls      = '0;
    cls.last = in_last;
    for (int ch = 0; ch < icc_pkg::NUM_DYES; ch++) begin
      if (ch < CHANNELS) begin
        sum_raw = sum_raw + icc_pkg::SUM_W'(in_dyes[ch]);
        for (int c = 0; c < icc_pkg::NUM_RGB; c++) begin
          cls.mix[c] = cls.mix[c]
                     + icc_pkg::MIX_W'(in_dyes[ch])
                     * icc_pkg::MIX_W'(cfg.colour[ch][8*(icc_pkg::NUM_RGB-1-c) +: 8]);
        end
      end
    end
    cls.sum = (sum_raw > icc_pkg::SUM_W'(SUM_MAX)) ? icc_pkg::SUM_W'(SUM_MAX) : sum_raw;
  end

  assign in_ready   = !st_valid_r || push_ready;
  assign push_valid = st_valid_r;
  assign push_item  = st_item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      st_valid_r <= 1'b1;
    end else if (push_ready) begin
      st_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      st_item_r <= cls;
    end
  end

endmodule

>>> hw/rtl/icc_queue.sv
`timescale 1ns / 1ps
module icc_queue #(
  parameter int DEPTH = icc_pkg::QUEUE_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_valid,
  output logic           push_ready,
  input  icc_pkg::item_t push_item,
  output logic           pop_valid,
  input  logic           pop_ready,
  output icc_pkg::item_t pop_item
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  icc_pkg::item_t   mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push, do_pop;

  assign push_ready = count_r < CNT_W'(DEPTH);
  assign pop_valid  = count_r != '0;
  assign pop_item   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

>>> hw/rtl/icc_div.sv
`timescale 1ns / 1ps
// 65536 / divisor, capped at 65535; two quotient bits per cycle
module icc_div (
  input  logic              clk,
  input  logic              rst_n,
  input  icc_pkg::div_req_t req,
  output icc_pkg::div_rsp_t rsp
);

  localparam int Q_W   = 18;
  localparam int STEPS = Q_W / 2;
  localparam int CNT_W = $clog2(STEPS + 1);
  localparam int D_W   = icc_pkg::SUM_W;

  logic [Q_W-1:0]   num_r, quot_r;
  logic [D_W-1:0]   rem_r, den_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r, done_r;
  logic [D_W-1:0]   rem_nxt;
  logic [1:0]       qbits;

  always_comb begin
    logic [D_W:0] r;
    rem_nxt = rem_r;
    qbits   = '0;
    for (int s = 0; s < 2; s++) begin
      r = {rem_nxt, num_r[Q_W-1-s]};
      if (r >= {1'b0, den_r}) begin
        r        = r - {1'b0, den_r};
        qbits[1-s] = 1'b1;
      end
      rem_nxt = r[D_W-1:0];
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = (quot_r > Q_W'(icc_pkg::RCP_CAP)) ? icc_pkg::RCP_CAP
                                                     : quot_r[icc_pkg::RCP_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(STEPS);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      num_r  <= Q_W'(icc_pkg::DIVIDEND);
      rem_r  <= '0;
      quot_r <= '0;
      den_r  <= req.divisor;
    end else if (busy_r) begin
      num_r  <= {num_r[Q_W-3:0], 2'b00};
      rem_r  <= rem_nxt;
      quot_r <= {quot_r[Q_W-3:0], qbits};
    end
  end

endmodule

>>> hw/rtl/icc_back.sv
`timescale 1ns / 1ps
module icc_back #(
  parameter int SUM_MAX = icc_pkg::SUM_MAX_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  icc_pkg::cfg_t               cfg,
  input  logic                        pop_valid,
  output logic                        pop_ready,
  input  icc_pkg::item_t              pop_item,
  output icc_pkg::div_req_t           div_req,
  input  icc_pkg::div_rsp_t           div_rsp,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [7:0]                  out_opacity,
  output logic [icc_pkg::HUE_W-1:0]   out_hue_red,
  output logic [icc_pkg::HUE_W-1:0]   out_hue_green,
  output logic [icc_pkg::HUE_W-1:0]   out_hue_blue
);

  localparam int ACC_W = icc_pkg::ACC_W;
  localparam int RCP_W = icc_pkg::RCP_W;
  localparam int SUM_W = icc_pkg::SUM_W;
  localparam int MIX_W = icc_pkg::MIX_W;
  localparam int NRGB  = icc_pkg::NUM_RGB;
  localparam int AP_W  = SUM_W + icc_pkg::GAIN_W;   // sum * gain
  localparam int TP_W  = (MIX_W - 8) + RCP_W;       // (mix>>8) * rcp
  localparam int T_W   = TP_W - 8;
  localparam int UP_W  = T_W + 8;                   // t * contrib
  localparam int HP_W  = ACC_W + RCP_W;             // acc * rcp

  typedef enum logic [10:0] {
    S_IDLE    = 11'b000_0000_0001,
    S_ALPHA   = 11'b000_0000_0010,
    S_CONTRIB = 11'b000_0000_0100,
    S_RDIV    = 11'b000_0000_1000,
    S_TERM1   = 11'b000_0001_0000,
    S_TERM2   = 11'b000_0010_0000,
    S_TRANS   = 11'b000_0100_0000,
    S_FIN     = 11'b000_1000_0000,
    S_HDIV    = 11'b001_0000_0000,
    S_HUE     = 11'b010_0000_0000,
    S_OUT     = 11'b100_0000_0000
  } state_t;

  state_t                          state_r;
  icc_pkg::item_t                  item_r;
  logic [7:0]                      alpha_r, contrib_r, trans_r;
  logic [RCP_W-1:0]                rcp_r;
  logic [T_W-1:0]                  t_r;
  logic [1:0]                      ch_r;
  logic [NRGB-1:0][ACC_W-1:0]      acc_r;
  logic [NRGB-1:0][7:0]            hue_r;
  logic                            opaque_r;
  logic                            out_valid_r;
  logic [7:0]                      out_opacity_r;
  logic [NRGB-1:0][7:0]            out_hue_r;

  logic [AP_W-1:0]  a_prod;
  logic [15:0]      c_prod;
  logic [TP_W-1:0]  t_prod;
  logic [UP_W-1:0]  u_prod;
  logic [ACC_W:0]   acc_sum;
  logic [HP_W-1:0]  h_prod;
  logic [7:0]       trans_dec;
  logic [ACC_W-1:0] cmax;
  logic [SUM_W-1:0] cmax_clip;
  logic             out_load;

  always_comb begin
    a_prod    = AP_W'(item_r.sum) * AP_W'(cfg.gain);
    c_prod    = 16'(trans_r) * 16'(alpha_r);
    t_prod    = TP_W'(item_r.mix[ch_r][MIX_W-1:8]) * TP_W'(rcp_r);
    u_prod    = UP_W'(t_r) * UP_W'(contrib_r);
    acc_sum   = (ACC_W+1)'(acc_r[ch_r]) + (ACC_W+1)'(u_prod[UP_W-1:8]);
    h_prod    = HP_W'(acc_r[ch_r]) * HP_W'(rcp_r);
    trans_dec = trans_r - contrib_r;
    cmax      = acc_r[0];
    if (acc_r[1] > cmax) cmax = acc_r[1];
    if (acc_r[2] > cmax) cmax = acc_r[2];
    cmax_clip = (cmax > ACC_W'(SUM_MAX)) ? SUM_W'(SUM_MAX) : cmax[SUM_W-1:0];
  end

  // divider is shared by the voxel reciprocal and the hue scale
  always_comb begin
    div_req.start   = 1'b0;
    div_req.divisor = item_r.sum;
    if (state_r == S_CONTRIB && c_prod[15:8] != 8'd0) begin
      div_req.start = 1'b1;
    end else if (state_r == S_FIN && item_r.last && cmax != '0) begin
      div_req.start   = 1'b1;
      div_req.divisor = cmax_clip;
    end
  end

  assign pop_ready     = (state_r == S_IDLE);
  assign out_load      = (state_r == S_OUT) && (!out_valid_r || out_ready);
  assign out_valid     = out_valid_r;
  assign out_opacity   = out_opacity_r;
  assign out_hue_red   = out_hue_r[0];
  assign out_hue_green = out_hue_r[1];
  assign out_hue_blue  = out_hue_r[2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      trans_r     <= icc_pkg::TRANS_FULL;
      acc_r       <= '0;
      opaque_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (pop_valid) state_r <= S_ALPHA;
        end
        S_ALPHA: begin
          if (opaque_r || item_r.sum == '0) state_r <= S_FIN;
          else                              state_r <= S_CONTRIB;
        end
        S_CONTRIB: begin
          if (c_prod[15:8] == 8'd0) state_r <= S_TRANS;
          else                      state_r <= S_RDIV;
        end
        S_RDIV: begin
          if (div_rsp.done) state_r <= S_TERM1;
        end
        S_TERM1: begin
          state_r <= S_TERM2;
        end
        S_TERM2: begin
          acc_r[ch_r] <= acc_sum[ACC_W] ? icc_pkg::ACC_CAP : acc_sum[ACC_W-1:0];
          if (ch_r == 2'(NRGB - 1)) state_r <= S_TRANS;
          else                      state_r <= S_TERM1;
        end
        S_TRANS: begin
          trans_r <= trans_dec;
          if (trans_dec <= icc_pkg::OPAQUE_LIMIT) opaque_r <= 1'b1;
          state_r <= S_FIN;
        end
        S_FIN: begin
          if (!item_r.last)     state_r <= S_IDLE;
          else if (cmax == '0)  state_r <= S_OUT;
          else                  state_r <= S_HDIV;
        end
        S_HDIV: begin
          if (div_rsp.done) state_r <= S_HUE;
        end
        S_HUE: begin
          if (ch_r == 2'(NRGB - 1)) state_r <= S_OUT;
        end
        S_OUT: begin
          if (out_load) begin
            trans_r  <= icc_pkg::TRANS_FULL;
            acc_r    <= '0;
            opaque_r <= 1'b0;
            state_r  <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && pop_valid) begin
      item_r <= pop_item;
    end
    if (state_r == S_ALPHA) begin
      alpha_r <= (a_prod[AP_W-1:8] > (AP_W-8)'(icc_pkg::ALPHA_CAP)) ? icc_pkg::ALPHA_CAP
                                                                    : a_prod[15:8];
    end
    if (state_r == S_CONTRIB) begin
      contrib_r <= c_prod[15:8];
    end
    if ((state_r == S_RDIV || state_r == S_HDIV) && div_rsp.done) begin
      rcp_r <= div_rsp.quot;
      ch_r  <= '0;
    end
    if (state_r == S_TERM1) begin
      t_r <= t_prod[TP_W-1:8];
    end
    if (state_r == S_TERM2 || state_r == S_HUE) begin
      ch_r <= ch_r + 1'b1;
    end
    if (state_r == S_HUE) begin
      hue_r[ch_r] <= (h_prod[HP_W-1:8] > (HP_W-8)'(8'd255)) ? 8'd255 : h_prod[15:8];
    end
    if (state_r == S_FIN && item_r.last && cmax == '0) begin
      hue_r <= '0;
    end
    if (out_load) begin
      out_opacity_r <= icc_pkg::TRANS_FULL - trans_r;
      out_hue_r     <= hue_r;
    end
  end

endmodule

>>> hw/rtl/ink_column_composite.sv
`timescale 1ns / 1ps
// Path: the front register and the queue, then the back end: a voxel that adds nothing
// passes alpha and finish (also contrib and trans if its sum is non-zero but it absorbs no
// light), one that adds colour also waits on the radix-4 reciprocal divider, then takes six
// multiply steps; a last voxel then runs the hue scale unless no colour was gathered.
// The back end takes a new voxel from the queue only once it is idle again.
// Reset (synchronous, rst_n low): registers back to defaults, column state cleared, queue empty.
module ink_column_composite #(
  parameter int CHANNELS    = icc_pkg::CHANNELS_DEF,
  parameter int SUM_MAX     = icc_pkg::SUM_MAX_DEF,
  parameter int QUEUE_DEPTH = icc_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // configuration writes
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [icc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [icc_pkg::COL_W-1:0]       cfg_data,
  // voxel items, front to back
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [icc_pkg::DYE_W-1:0]       in_dye_a,
  input  logic [icc_pkg::DYE_W-1:0]       in_dye_b,
  input  logic [icc_pkg::DYE_W-1:0]       in_dye_c,
  input  logic [icc_pkg::DYE_W-1:0]       in_dye_d,
  input  logic                            in_last_in_column,
  // one result item per column
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [7:0]                      out_opacity,
  output logic [icc_pkg::HUE_W-1:0]       out_hue_red,
  output logic [icc_pkg::HUE_W-1:0]       out_hue_green,
  output logic [icc_pkg::HUE_W-1:0]       out_hue_blue
);

  icc_pkg::cfg_t     cfg_r;
  icc_pkg::item_t    push_item, pop_item;
  icc_pkg::div_req_t div_req;
  icc_pkg::div_rsp_t div_rsp;
  logic              push_valid, push_ready, pop_valid, pop_ready;

  // Registers are always writable; writes are meant for when no item is in flight.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gain   <= icc_pkg::GAIN_RST;
      cfg_r.colour <= {icc_pkg::NUM_DYES{icc_pkg::COLOUR_RST}};
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        icc_pkg::REG_GAIN:    cfg_r.gain      <= cfg_data[icc_pkg::GAIN_W-1:0];
        icc_pkg::REG_COLOUR0: cfg_r.colour[0] <= cfg_data;
        icc_pkg::REG_COLOUR1: cfg_r.colour[1] <= cfg_data;
        icc_pkg::REG_COLOUR2: cfg_r.colour[2] <= cfg_data;
        icc_pkg::REG_COLOUR3: cfg_r.colour[3] <= cfg_data;
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  // Front end: sums the dyes and forms the colour mixes, one item per cycle while the queue accepts them.
  icc_front #(
    .CHANNELS (CHANNELS),
    .SUM_MAX  (SUM_MAX)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_dyes    ({in_dye_d, in_dye_c, in_dye_b, in_dye_a}),
    .in_last    (in_last_in_column),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  // Short queue so the front keeps taking items while the back iterates.
  icc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  // Shared reciprocal unit: voxel sum and column hue scale.
  icc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // Back end: compositing sequencer, accumulators and output register.
  icc_back #(
    .SUM_MAX (SUM_MAX)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg_r),
    .pop_valid     (pop_valid),
    .pop_ready     (pop_ready),
    .pop_item      (pop_item),
    .div_req       (div_req),
    .div_rsp       (div_rsp),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_opacity   (out_opacity),
    .out_hue_red   (out_hue_red),
    .out_hue_green (out_hue_green),
    .out_hue_blue  (out_hue_blue)
  );

endmodule

>>> hw/rtl/icc_checker.sv
`timescale 1ns / 1ps
module icc_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_opacity,
  input logic [7:0] out_hue_red,
  input logic [7:0] out_hue_green,
  input logic [7:0] out_hue_blue
);

  // result register empties on reset
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_opacity)
      && $stable(out_hue_red) && $stable(out_hue_green) && $stable(out_hue_blue))
    else $error("stalled result changed");

  // no light absorbed means no colour gathered
  a_clear_no_hue: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_opacity == 8'd0 |->
      out_hue_red == 8'd0 && out_hue_green == 8'd0 && out_hue_blue == 8'd0)
    else $error("hue on a transparent column");

endmodule

bind ink_column_composite icc_checker u_icc_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_opacity   (out_opacity),
  .out_hue_red   (out_hue_red),
  .out_hue_green (out_hue_green),
  .out_hue_blue  (out_hue_blue)
);
